[rtl/sha1_pkg.sv]
// ============================================================================
// sha1_pkg
// Shared types, round constants and helper functions of the SHA-1 hasher.
// ============================================================================
package sha1_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 5;
    localparam int ROUNDS      = 80;
    localparam int COUNT_W     = 61;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,    // take message bytes
        ST_PAD,     // write padding words into the block memory
        ST_CINIT,   // load working variables from the chain memory
        ST_ROUND,   // one SHA-1 round per cycle
        ST_FINAL,   // add working variables into the chain memory
        ST_ORD,     // read one digest word
        ST_OLD      // hand the digest word to the output register
    } state_t;

    // What follows a compression
    typedef enum logic [1:0] {
        PH_MSG,      // block of message bytes
        PH_PAD_A,    // padding block without the length field
        PH_PAD_LAST  // block that carries the length field
    } phase_t;

    localparam logic [31:0] K_0 = 32'h5A82_7999;
    localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K_3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_MARK = 8'b1000_0000;

    // Initial chain value of one word
    function automatic logic [31:0] h_init(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0:    h = 32'h6745_2301;
            3'd1:    h = 32'hEFCD_AB89;
            3'd2:    h = 32'h98BA_DCFE;
            3'd3:    h = 32'h1032_5476;
            3'd4:    h = 32'hC3D2_E1F0;
            default: h = '0;
        endcase
        return h;
    endfunction

    // Round function by round number
    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        priority if (t < 7'd20)
            f = (b & c) | (~b & d);
        else if (t < 7'd40)
            f = b ^ c ^ d;
        else if (t < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

    // Round constant by round number
    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        priority if (t < 7'd20)
            k = K_0;
        else if (t < 7'd40)
            k = K_1;
        else if (t < 7'd60)
            k = K_2;
        else
            k = K_3;
        return k;
    endfunction

endpackage

[rtl/sha1_byte_if.sv]
// ============================================================================
// sha1_byte_if
// Byte channel into the hasher: one message byte with valid and end flags.
// ============================================================================
interface sha1_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;

    modport source (output valid, data_byte, byte_valid, last_byte, input ready);
    modport sink   (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

[rtl/sha1_digest_if.sv]
// ============================================================================
// sha1_digest_if
// Digest channel out of the hasher: one 32-bit digest word per transfer.
// ============================================================================
interface sha1_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/sha1_stream_hasher.sv]
// ============================================================================
// sha1_stream_hasher
// Streaming SHA-1: bytes in, five digest words out at the end of a message.
// ============================================================================
// Usage:
//   byte_in carries one transfer per byte: data_byte with byte_valid, and
//   last_byte to end the message. last_byte with byte_valid low ends the
//   message without a byte (an empty message is legal).
//   digest_out returns H0..H4 as five transfers, word_index 0..4, last_word
//   on the fifth.
// Timing:
//   Bytes are taken only in the idle state. The byte that fills a 64-byte
//   block starts a compression: chain reads, 80 rounds at one per cycle
//   through the single round adder, then write back.
//   At message end: 1 to 16 padding word writes, one or two compressions,
//   then for each digest word a chain memory read and a load.
// Reset:
//   Control clears at once; the chain memory has a valid bit per word, so a
//   word never written reads as its initial value. No clearing pass.
// Stalls:
//   The digest word waits in an output register; while it waits the block
//   stops before loading the next word. Once the fifth word sits in the
//   register, new bytes are taken again.
// ============================================================================
module sha1_stream_hasher (
    input  logic   clk,
    input  logic   rst_n,
    sha1_byte_if.sink     byte_in,
    sha1_digest_if.source digest_out
);
    import sha1_pkg::*;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    phase_t               phase_reg;
    logic                 fin_reg;
    logic [6:0]           seq_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [23:0]          acc_reg;
    logic [3:0]           pad_w_reg;
    logic                 pad_first_reg;
    logic                 pass2_reg;
    logic [2:0]           oidx_reg;
    logic [CHAIN_WORDS-1:0] chain_vld_reg;

    logic                 out_valid_reg;
    logic [31:0]          out_word_reg;
    logic [2:0]           out_idx_reg;

    logic [31:0]          a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]          sched_reg [BLOCK_WORDS];

    logic [31:0]          blk_mem [BLOCK_WORDS];
    logic [31:0]          blk_rdata_reg;
    logic [31:0]          chain_mem [CHAIN_WORDS];
    logic [31:0]          chain_rdata_reg;
    logic                 chain_rvld_reg;
    logic [2:0]           chain_raddr_q_reg;

    logic                 in_ready;
    logic                 in_fire;
    logic                 out_load;
    logic [5:0]           pos;
    logic                 pad_len;
    logic [3:0]           pad_cur;
    logic [31:0]          pad_word;
    logic [63:0]          bit_len;

    logic                 blk_we;
    logic [3:0]           blk_waddr;
    logic [31:0]          blk_wdata;
    logic                 blk_re;
    logic [3:0]           blk_raddr;
    logic                 chain_re;
    logic [2:0]           chain_raddr;
    logic                 chain_we;
    logic [2:0]           chain_waddr;
    logic [31:0]          chain_wdata;
    logic [31:0]          chain_eff;

    logic [31:0]          w_cur;
    logic [31:0]          w_exp;
    logic [31:0]          round_tmp;

    // ------------------------------------------------------------------
    // Common terms
    // ------------------------------------------------------------------
    assign pos      = count_reg[5:0];
    assign in_fire  = byte_in.valid && in_ready;
    assign out_load = (state_reg == ST_OLD) && (!out_valid_reg || digest_out.ready);
    assign bit_len  = {count_reg, 3'b000};
    assign pad_len  = pass2_reg || (count_reg[5:3] != 3'd7);
    assign pad_cur  = pad_first_reg ? count_reg[5:2] : pad_w_reg;
    assign chain_eff = chain_rvld_reg ? chain_rdata_reg : h_init(chain_raddr_q_reg);

    // Build the current padding word
    always_comb
    begin
        pad_word = '0;
        if (pad_first_reg)
        begin
            unique case (count_reg[1:0])
                2'd0: pad_word = {PAD_MARK, 24'h0};
                2'd1: pad_word = {acc_reg[7:0], PAD_MARK, 16'h0};
                2'd2: pad_word = {acc_reg[15:0], PAD_MARK, 8'h0};
                2'd3: pad_word = {acc_reg[23:0], PAD_MARK};
            endcase
        end
        else if (pad_len && pad_cur == 4'd14)
            pad_word = bit_len[63:32];
        else if (pad_len && pad_cur == 4'd15)
            pad_word = bit_len[31:0];
    end

    // Message schedule and round sum
    assign w_exp = {sched_reg[13][30:0] ^ sched_reg[8][30:0] ^ sched_reg[2][30:0]
                    ^ sched_reg[0][30:0],
                    sched_reg[13][31] ^ sched_reg[8][31] ^ sched_reg[2][31]
                    ^ sched_reg[0][31]};
    assign w_cur = (seq_reg[6:4] == 3'd0) ? blk_rdata_reg : w_exp;
    assign round_tmp = {a_reg[26:0], a_reg[31:27]} + round_f(seq_reg, b_reg, c_reg, d_reg)
                       + e_reg + w_cur + round_k(seq_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (byte_in.byte_valid && pos == 6'd63)
                        state_next = ST_CINIT;
                    else if (byte_in.last_byte)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (pad_cur == 4'd15)
                    state_next = ST_CINIT;
            end
            ST_CINIT:
            begin
                if (seq_reg == 7'd5)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (seq_reg == 7'(ROUNDS - 1))
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (seq_reg == 7'd5)
                begin
                    unique case (phase_reg)
                        PH_MSG:      state_next = fin_reg ? ST_PAD : ST_IDLE;
                        PH_PAD_A:    state_next = ST_PAD;
                        PH_PAD_LAST: state_next = ST_ORD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ORD:
                state_next = ST_OLD;
            ST_OLD:
            begin
                if (out_load)
                    state_next = (oidx_reg == 3'd4) ? ST_IDLE : ST_ORD;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Memory controls and handshake
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready    = 1'b0;
        blk_we      = 1'b0;
        blk_waddr   = pos[5:2];
        blk_wdata   = {acc_reg, byte_in.data_byte};
        blk_re      = 1'b0;
        blk_raddr   = '0;
        chain_re    = 1'b0;
        chain_raddr = seq_reg[2:0];
        chain_we    = 1'b0;
        chain_waddr = seq_reg[2:0] - 3'd1;
        chain_wdata = chain_eff + a_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                blk_we   = in_fire && byte_in.byte_valid && (pos[1:0] == 2'b11);
            end
            ST_PAD:
            begin
                blk_we    = 1'b1;
                blk_waddr = pad_cur;
                blk_wdata = pad_word;
            end
            ST_CINIT:
            begin
                chain_re = (seq_reg < 7'd5);
                blk_re   = (seq_reg == 7'd5);
            end
            ST_ROUND:
            begin
                blk_re    = (seq_reg < 7'(BLOCK_WORDS - 1));
                blk_raddr = seq_reg[3:0] + 4'd1;
            end
            ST_FINAL:
            begin
                chain_re = (seq_reg < 7'd5);
                chain_we = (seq_reg != 7'd0);
            end
            ST_ORD:
            begin
                chain_re    = 1'b1;
                chain_raddr = oidx_reg;
            end
            ST_OLD:
                ;
            default:
                ;
        endcase
    end

    assign byte_in.ready          = in_ready;
    assign digest_out.valid       = out_valid_reg;
    assign digest_out.digest_word = out_word_reg;
    assign digest_out.word_index  = out_idx_reg;
    assign digest_out.last_word   = (out_idx_reg == 3'd4);

    // ------------------------------------------------------------------
    // Memories: one write and one registered read per cycle each
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (blk_we)
            blk_mem[blk_waddr] <= blk_wdata;
        if (blk_re)
            blk_rdata_reg <= blk_mem[blk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (chain_we)
            chain_mem[chain_waddr] <= chain_wdata;
        if (chain_re)
        begin
            chain_rdata_reg   <= chain_mem[chain_raddr];
            chain_raddr_q_reg <= chain_raddr;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_MSG;
            fin_reg        <= 1'b0;
            seq_reg        <= '0;
            count_reg      <= '0;
            pad_w_reg      <= '0;
            pad_first_reg  <= 1'b0;
            pass2_reg      <= 1'b0;
            oidx_reg       <= '0;
            chain_vld_reg  <= '0;
            chain_rvld_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Advance the step counter inside a state, restart on change
            if (state_next == state_reg)
                seq_reg <= seq_reg + 7'd1;
            else
                seq_reg <= '0;

            // Take a byte, remember a pending message end
            if (in_fire)
            begin
                if (byte_in.byte_valid)
                    count_reg <= count_reg + COUNT_W'(1);
                fin_reg <= byte_in.last_byte;
            end

            // Pick the continuation of a compression
            if (state_reg == ST_IDLE && state_next == ST_CINIT)
                phase_reg <= PH_MSG;
            else if (state_reg == ST_PAD && state_next == ST_CINIT)
                phase_reg <= pad_len ? PH_PAD_LAST : PH_PAD_A;

            // Padding word pointer
            if (state_reg != ST_PAD && state_next == ST_PAD)
            begin
                pass2_reg     <= (state_reg == ST_FINAL) && (phase_reg == PH_PAD_A);
                pad_first_reg <= !((state_reg == ST_FINAL) && (phase_reg == PH_PAD_A));
                pad_w_reg     <= '0;
            end
            else if (state_reg == ST_PAD)
            begin
                pad_first_reg <= 1'b0;
                pad_w_reg     <= pad_cur + 4'd1;
            end

            // Track chain words written since the last digest
            if (chain_re)
                chain_rvld_reg <= chain_vld_reg[chain_raddr];
            if (chain_we)
                chain_vld_reg[chain_waddr] <= 1'b1;

            // Digest word sequencing; drop the chain after the fifth word
            if (state_reg == ST_FINAL && state_next == ST_ORD)
                oidx_reg <= '0;
            else if (out_load)
            begin
                oidx_reg <= oidx_reg + 3'd1;
                if (oidx_reg == 3'd4)
                begin
                    chain_vld_reg <= '0;
                    count_reg     <= '0;
                    fin_reg       <= 1'b0;
                end
            end

            // Output register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (digest_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // Collect bytes of the current word
        if (in_fire && byte_in.byte_valid)
            acc_reg <= {acc_reg[15:0], byte_in.data_byte};

        // Load working variables, shifting in H0..H4
        if (state_reg == ST_CINIT && seq_reg != 7'd0)
        begin
            a_reg <= b_reg;
            b_reg <= c_reg;
            c_reg <= d_reg;
            d_reg <= e_reg;
            e_reg <= chain_eff;
        end
        // One round
        else if (state_reg == ST_ROUND)
        begin
            a_reg <= round_tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        // Shift the next variable up for the chain update
        else if (state_reg == ST_FINAL && seq_reg != 7'd0)
        begin
            a_reg <= b_reg;
            b_reg <= c_reg;
            c_reg <= d_reg;
            d_reg <= e_reg;
        end

        // Schedule window, oldest word at the bottom
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
                sched_reg[i] <= sched_reg[i + 1];
            sched_reg[BLOCK_WORDS - 1] <= w_cur;
        end

        if (out_load)
        begin
            out_word_reg <= chain_eff;
            out_idx_reg  <= oidx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_chain_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && oidx_reg == 3'd4) |=> (chain_vld_reg == '0 && count_reg == '0))
        else $error("chain not returned to its initial value after the digest");

    a_no_blk_write_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND || state_reg == ST_CINIT) |-> !blk_we)
        else $error("block memory written during compression");

    a_chain_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_we && chain_re) |-> (chain_waddr != chain_raddr))
        else $error("chain memory read and write hit the same word");

endmodule
